>>> src/matched_filter_gradient_assert.svh
// Assertion macros for the matched filter gradient block.
`ifndef MATCHED_FILTER_GRADIENT_ASSERT_SVH
`define MATCHED_FILTER_GRADIENT_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked check, quiet while reset is asserted
`define MFG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also evaluated during reset
`define MFG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFG_ASSERT(label, prop, msg)
`define MFG_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> src/mfg_pkg.sv
// Shared constants, types and arithmetic helpers of the matched filter gradient block.
package mfg_pkg;

    localparam int NUM_PIXELS = 16384;
    localparam int ADDR_W     = $clog2(NUM_PIXELS);
    localparam int IDX_W      = 14;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = 32;
    localparam int ACC_W      = 48;
    localparam int MEM_W      = SUM_W + 2 * ACC_W;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 240;

    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic KIND_GRAD  = 1'b0;
    localparam logic KIND_IMAGE = 1'b1;
    localparam logic CFG_COS    = 1'b0;
    localparam logic CFG_SIN    = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic             valid;
        logic             cmd;
        logic             last;
        logic             in_range;
        logic [IDX_W-1:0] idx;
    } stage_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] d;
        logic signed [PROD_W-1:0] gx;
        logic signed [PROD_W-1:0] gy;
        logic signed [PROD_W-1:0] ic;
        logic signed [PROD_W-1:0] is;
    } prod_t;

    function automatic logic signed [PROD_W-1:0] mul_q15(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        mul_q15 = $signed({{DATA_W{a[DATA_W-1]}}, a}) * $signed({{DATA_W{b[DATA_W-1]}}, b});
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = $signed({a[ACC_W-1], a}) + $signed({{(ACC_W+1-PROD_W){b[PROD_W-1]}}, b});
        if (s[ACC_W] != s[ACC_W-1])
            sat_acc = s[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            sat_acc = s[ACC_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W+1-DATA_W){b[DATA_W-1]}}, b});
        if (s[SUM_W] != s[SUM_W-1])
            sat_sum = s[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            sat_sum = s[SUM_W-1:0];
    endfunction

endpackage

>>> src/matched_filter_gradient.sv
// Top level of the matched filter gradient block: stream ports, image memory RMW, sums.
// A result passes stage 1, stage 2 and the output register before it is on m_tvalid.
// Throughput: one item per cycle; the pipeline holds only while a result waits in
// the output register and the item in the last stage has another result to give.
// Reset: control state clears and the gains take 32767 (cos) and 0 (sin) at once, then the
// image memory is zeroed one entry per cycle over all NUM_PIXELS (16384) entries with s_tready low; cfg writes go on.
module matched_filter_gradient (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_index, pixel, bias, coeff_x, coeff_y, zero pad
    input  logic [mfg_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sub_number, grad_x, grad_y, image_sum, image_x, image_y
    output logic [mfg_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // result_kind
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [mfg_pkg::DATA_W-1:0]         cfg_data
);
    import mfg_pkg::*;

    localparam int PIX_LO = IDX_W;
    localparam int BIAS_LO = PIX_LO + DATA_W;
    localparam int CX_LO = BIAS_LO + DATA_W;
    localparam int CY_LO = CX_LO + DATA_W;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic signed [DATA_W-1:0] cos_gain_reg;
    logic signed [DATA_W-1:0] sin_gain_reg;

    logic        adv;
    logic        s_accept;
    stage_ctrl_t in_ctrl;
    stage_ctrl_t s1_ctrl;
    stage_ctrl_t s2_ctrl;
    prod_t       s2_prod;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [MEM_W-1:0]     ram_wdata;
    logic [MEM_W-1:0]     ram_rdata;

    logic signed [SUM_W-1:0] old_sum_reg;
    logic signed [ACC_W-1:0] old_x_reg;
    logic signed [ACC_W-1:0] old_y_reg;
    logic signed [SUM_W-1:0] new_sum;
    logic signed [ACC_W-1:0] new_x;
    logic signed [ACC_W-1:0] new_y;
    logic [MEM_W-1:0]        new_word;
    logic [MEM_W-1:0]        fwd_word;
    logic                    s2_write;

    logic                 wb_valid_reg;
    logic [IDX_W-1:0]     wb_idx_reg;
    logic [MEM_W-1:0]     wb_data_reg;

    logic signed [ACC_W-1:0] gx_acc_reg;
    logic signed [ACC_W-1:0] gy_acc_reg;
    logic signed [ACC_W-1:0] gx_new;
    logic signed [ACC_W-1:0] gy_new;
    logic [DATA_W-1:0]       sub_cnt_reg;
    logic                    grad_step;
    logic                    grad_emit;

    logic                   out_load;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;
    logic                   m_tuser_reg;
    logic                   m_tuser_next;

    // ---------------- handshake and stage control ----------------
    assign adv = !(s2_ctrl.valid && (s2_ctrl.cmd == CMD_READ || s2_ctrl.last)
                   && m_tvalid_reg && !m_tready);
    assign s_tready = (state_reg == ST_RUN) && adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_ctrl.valid    = s_accept;
        in_ctrl.cmd      = s_tuser;
        in_ctrl.last     = s_tlast;
        in_ctrl.idx      = s_tdata[IDX_W-1:0];
        in_ctrl.in_range = int'(s_tdata[IDX_W-1:0]) < NUM_PIXELS;
    end

    mfg_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctrl  (in_ctrl),
        .pixel    ($signed(s_tdata[PIX_LO +: DATA_W])),
        .bias     ($signed(s_tdata[BIAS_LO +: DATA_W])),
        .coeff_x  ($signed(s_tdata[CX_LO +: DATA_W])),
        .coeff_y  ($signed(s_tdata[CY_LO +: DATA_W])),
        .cos_gain (cos_gain_reg),
        .sin_gain (sin_gain_reg),
        .s1_ctrl  (s1_ctrl),
        .s2_ctrl  (s2_ctrl),
        .s2_prod  (s2_prod)
    );

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_gain_reg <= 16'sd32767;
            sin_gain_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COS: cos_gain_reg <= cfg_data;
                CFG_SIN: sin_gain_reg <= cfg_data;
            endcase
        end
    end

    // ---------------- clearing pass ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(NUM_PIXELS - 1))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ---------------- image memory read-modify-write ----------------
    assign new_sum  = sat_sum(old_sum_reg, s2_prod.d);
    assign new_x    = sat_acc(old_x_reg, s2_prod.ic);
    assign new_y    = sat_acc(old_y_reg, s2_prod.is);
    assign new_word = {new_y, new_x, new_sum};
    assign s2_write = s2_ctrl.valid && (s2_ctrl.cmd == CMD_PIXEL) && s2_ctrl.in_range;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = adv && s2_write;
            ram_waddr = ADDR_W'(s2_ctrl.idx);
            ram_wdata = new_word;
        end
    end

    mfg_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_PIXELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (ADDR_W'(in_ctrl.idx)),
        .rdata (ram_rdata)
    );

    // the read of the item in stage 1 misses the write in flight in stage 2 and
    // the write committed at the edge that loaded stage 1
    always_comb
    begin
        if (s2_write && s2_ctrl.idx == s1_ctrl.idx)
            fwd_word = new_word;
        else if (wb_valid_reg && wb_idx_reg == s1_ctrl.idx)
            fwd_word = wb_data_reg;
        else
            fwd_word = ram_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else if (adv)
            wb_valid_reg <= s2_write;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wb_idx_reg  <= s2_ctrl.idx;
            wb_data_reg <= new_word;
            old_sum_reg <= fwd_word[SUM_W-1:0];
            old_x_reg   <= fwd_word[SUM_W +: ACC_W];
            old_y_reg   <= fwd_word[SUM_W+ACC_W +: ACC_W];
        end
    end

    // ---------------- gradient sums ----------------
    assign gx_new    = sat_acc(gx_acc_reg, s2_prod.gx);
    assign gy_new    = sat_acc(gy_acc_reg, s2_prod.gy);
    assign grad_step = adv && s2_ctrl.valid && (s2_ctrl.cmd == CMD_PIXEL);
    assign grad_emit = grad_step && s2_ctrl.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_acc_reg  <= '0;
            gy_acc_reg  <= '0;
            sub_cnt_reg <= '0;
        end
        else if (grad_emit)
        begin
            gx_acc_reg  <= '0;
            gy_acc_reg  <= '0;
            sub_cnt_reg <= sub_cnt_reg + 1'b1;
        end
        else if (grad_step)
        begin
            gx_acc_reg <= gx_new;
            gy_acc_reg <= gy_new;
        end
    end

    // ---------------- output register ----------------
    assign out_load = adv && s2_ctrl.valid && (s2_ctrl.cmd == CMD_READ || s2_ctrl.last);

    always_comb
    begin
        if (s2_ctrl.cmd == CMD_READ)
        begin
            m_tuser_next = KIND_IMAGE;
            if (s2_ctrl.in_range)
                m_tdata_next = {old_y_reg, old_x_reg, old_sum_reg,
                                {(2*ACC_W+DATA_W){1'b0}}};
            else
                m_tdata_next = '0;
        end
        else
        begin
            m_tuser_next = KIND_GRAD;
            m_tdata_next = {{(SUM_W+2*ACC_W){1'b0}}, gy_new, gx_new, sub_cnt_reg};
        end
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks ----------------
`include "matched_filter_gradient_assert.svh"

    `MFG_ASSERT(a_clear_empty, (state_reg == ST_CLEAR) |-> (!s1_ctrl.valid && !s2_ctrl.valid), "pipeline busy during memory clear")
    `MFG_ASSERT(a_no_overwrite, out_load |-> (!m_tvalid_reg || m_tready), "waiting result overwritten")
    `MFG_ASSERT(a_grad_cleared, grad_emit |=> (gx_acc_reg == '0 && gy_acc_reg == '0), "gradient sums not cleared after emit")
    `MFG_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!m_tvalid && !s_tready), "handshake active in reset")

endmodule

>>> src/mfg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents when both ports hit the same entry
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mfg_mac.sv
// Difference and coefficient multiply stages of the matched filter pipeline.
module mfg_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  mfg_pkg::stage_ctrl_t                in_ctrl,
    input  logic signed [mfg_pkg::DATA_W-1:0]   pixel,
    input  logic signed [mfg_pkg::DATA_W-1:0]   bias,
    input  logic signed [mfg_pkg::DATA_W-1:0]   coeff_x,
    input  logic signed [mfg_pkg::DATA_W-1:0]   coeff_y,
    input  logic signed [mfg_pkg::DATA_W-1:0]   cos_gain,
    input  logic signed [mfg_pkg::DATA_W-1:0]   sin_gain,
    output mfg_pkg::stage_ctrl_t                s1_ctrl,
    output mfg_pkg::stage_ctrl_t                s2_ctrl,
    output mfg_pkg::prod_t                      s2_prod
);
    import mfg_pkg::*;

    stage_ctrl_t              s1_ctrl_reg;
    stage_ctrl_t              s2_ctrl_reg;
    logic signed [DATA_W-1:0] d_reg;
    logic signed [DATA_W-1:0] cx_reg;
    logic signed [DATA_W-1:0] cy_reg;
    prod_t                    prod_reg;
    prod_t                    prod_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctrl_reg <= in_ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_comb
    begin
        prod_next.d  = d_reg;
        prod_next.gx = mul_q15(cx_reg, d_reg);
        prod_next.gy = mul_q15(cy_reg, d_reg);
        prod_next.ic = mul_q15(d_reg, cos_gain);
        prod_next.is = mul_q15(d_reg, sin_gain);
    end

    // difference wraps to 16 bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= pixel - bias;
            cx_reg   <= coeff_x;
            cy_reg   <= coeff_y;
            prod_reg <= prod_next;
        end
    end

    assign s1_ctrl = s1_ctrl_reg;
    assign s2_ctrl = s2_ctrl_reg;
    assign s2_prod = prod_reg;

endmodule
